>>> design/c_subset_lexer_top_assert.svh
// Assertion macros shared by the lexer modules.
// Depends on nothing; included by c_sl_core and c_sl_fifo.
`ifndef C_SUBSET_LEXER_TOP_ASSERT_SVH
`define C_SUBSET_LEXER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define C_SL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c_sl: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define C_SL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c_sl: next-cycle check failed");

`endif

>>> design/c_sl_pkg.sv
// Shared types, token codes, limits and keyword table for the C subset lexer.
// No dependencies; used by c_sl_core, c_sl_fifo and c_subset_lexer_top.
`timescale 1ns / 1ps

package c_sl_pkg;

  // Token limits
  localparam int MAX_IDENT_LEN  = 49;
  localparam int MAX_STRING_LEN = 1024;
  localparam int MAX_DIGITS     = 10;
  localparam logic [30:0] INT_LIMIT = 31'h7fff_ffff;

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Token codes
  localparam logic [5:0] KIND_CONST   = 6'd0;
  localparam logic [5:0] KIND_INT     = 6'd1;
  localparam logic [5:0] KIND_CHAR    = 6'd2;
  localparam logic [5:0] KIND_VOID    = 6'd3;
  localparam logic [5:0] KIND_IDENT   = 6'd4;
  localparam logic [5:0] KIND_IF      = 6'd5;
  localparam logic [5:0] KIND_ELSE    = 6'd6;
  localparam logic [5:0] KIND_WHILE   = 6'd7;
  localparam logic [5:0] KIND_FOR     = 6'd8;
  localparam logic [5:0] KIND_SCANF   = 6'd9;
  localparam logic [5:0] KIND_PRINTF  = 6'd10;
  localparam logic [5:0] KIND_RETURN  = 6'd11;
  localparam logic [5:0] KIND_EQ      = 6'd12;
  localparam logic [5:0] KIND_NE      = 6'd13;
  localparam logic [5:0] KIND_GT      = 6'd14;
  localparam logic [5:0] KIND_GE      = 6'd15;
  localparam logic [5:0] KIND_LT      = 6'd16;
  localparam logic [5:0] KIND_LE      = 6'd17;
  localparam logic [5:0] KIND_LPAREN  = 6'd18;
  localparam logic [5:0] KIND_RPAREN  = 6'd19;
  localparam logic [5:0] KIND_LBRACK  = 6'd20;
  localparam logic [5:0] KIND_RBRACK  = 6'd21;
  localparam logic [5:0] KIND_LBRACE  = 6'd22;
  localparam logic [5:0] KIND_RBRACE  = 6'd23;
  localparam logic [5:0] KIND_COMMA   = 6'd24;
  localparam logic [5:0] KIND_SEMI    = 6'd25;
  localparam logic [5:0] KIND_ASSIGN  = 6'd26;
  localparam logic [5:0] KIND_NUMBER  = 6'd27;
  localparam logic [5:0] KIND_CHARCON = 6'd28;
  localparam logic [5:0] KIND_STRING  = 6'd29;
  localparam logic [5:0] KIND_PLUS    = 6'd30;
  localparam logic [5:0] KIND_MINUS   = 6'd31;
  localparam logic [5:0] KIND_STAR    = 6'd32;
  localparam logic [5:0] KIND_SLASH   = 6'd33;
  localparam logic [5:0] KIND_MAIN    = 6'd34;
  localparam logic [5:0] KIND_ERROR   = 6'd35;

  // Keywords, lower case, right-justified in a six-byte window
  localparam int KW_COUNT = 12;
  localparam logic [47:0] KW_WORD [KW_COUNT] = '{
    48'h0063_6f6e_7374,
    48'h0000_0069_6e74,
    48'h0000_6368_6172,
    48'h0000_766f_6964,
    48'h0000_0000_6966,
    48'h0000_656c_7365,
    48'h0077_6869_6c65,
    48'h0000_0066_6f72,
    48'h0073_6361_6e66,
    48'h7072_696e_7466,
    48'h7265_7475_726e,
    48'h0000_6d61_696e
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd5, 3'd3, 3'd4, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd5, 3'd6, 3'd6, 3'd4
  };
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    KIND_CONST, KIND_INT, KIND_CHAR, KIND_VOID, KIND_IF, KIND_ELSE,
    KIND_WHILE, KIND_FOR, KIND_SCANF, KIND_PRINTF, KIND_RETURN, KIND_MAIN
  };

  // One source item
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } src_t;

  // One token
  typedef struct packed {
    logic [5:0]  token_kind;
    logic [30:0] token_value;
    logic [31:0] token_start;
    logic [10:0] token_length;
    logic        value_saturated;
    logic        last_of_run;
  } tok_t;

  // Tokens produced by one item, in order, with their count
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } tok_pair_t;

  // Match an identifier against the keyword table
  function automatic logic [5:0] keyword_kind(input logic [47:0] window,
                                              input logic [10:0] len);
    logic [5:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (len == 11'(KW_LEN[k]) && window == KW_WORD[k]) begin
        kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

endpackage

>>> design/c_subset_lexer_top.sv
// Top level of the C subset lexer: input register, lexer core, result queue.
// Depends on c_sl_pkg, c_sl_core and c_sl_fifo.
//
//   channel  dir  handshake              payload
//   src      in   src_valid/src_ready    c_sl_pkg::src_t (one byte or end mark)
//   tok      out  tok_valid/tok_ready    c_sl_pkg::tok_t (one token)
//
// One source byte per cycle: a byte is held in the input register, then the core lexes
// it and writes its zero, one or two tokens into a four-entry queue. The queue drains
// one token per cycle while tok_ready is high, so bytes that each end two tokens run
// at the rate of the output; the core takes a byte only while two queue slots are free.
// Synchronous reset returns the lexer to between-tokens at offset zero; no sweep.
`timescale 1ns / 1ps

module c_subset_lexer_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_ready,
  input  c_sl_pkg::src_t  src,
  output logic            tok_valid,
  input  logic            tok_ready,
  output c_sl_pkg::tok_t  tok
);

  c_sl_pkg::src_t      in_q;
  logic                in_vld;
  logic                fire;
  logic                room;
  c_sl_pkg::tok_pair_t push;

  // Lex the held byte when the queue can take its tokens
  assign fire      = in_vld && room;
  assign src_ready = !in_vld || fire;

  // Hold one input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (src_ready) begin
      in_vld <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      in_q <= src;
    end
  end

  c_sl_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .src  (in_q),
    .push (push)
  );

  c_sl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

endmodule

>>> design/c_sl_core.sv
// Lexer state and per-byte token logic: one item in, up to two tokens out.
// Depends on c_sl_pkg and c_subset_lexer_top_assert.svh.
`timescale 1ns / 1ps
`include "c_subset_lexer_top_assert.svh"

module c_sl_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  c_sl_pkg::src_t       src,
  output c_sl_pkg::tok_pair_t  push
);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_EQ, M_BANG, M_GT, M_LT, M_NUMBER, M_QUOTE, M_CHARGOT, M_STRING
  } mode_t;

  mode_t       mode, mode_next;
  logic [47:0] window, window_next;
  logic [30:0] acc, acc_next;
  logic [3:0]  digits, digits_next;
  logic        sat, sat_next;
  logic [7:0]  pend, pend_next;
  logic [10:0] run_len, run_len_next;
  logic [31:0] tok_begin, tok_begin_next;
  logic [31:0] byte_off, byte_off_next;

  logic [7:0]  ch, lc;
  logic [3:0]  dig;
  logic        ch_upper, ch_letter, ch_digit, ch_print;
  logic [34:0] prod;
  logic        ovf;

  c_sl_pkg::tok_t fl, st, ct, first;
  logic           fl_vld, st_vld, ct_vld, first_vld, absorb, use_start;
  mode_t          st_mode, ct_mode;

  // Classify the incoming byte
  assign ch        = src.char_byte;
  assign ch_upper  = (ch >= "A") && (ch <= "Z");
  assign ch_letter = ((ch >= "a") && (ch <= "z")) || ch_upper || (ch == "_");
  assign ch_digit  = (ch >= "0") && (ch <= "9");
  assign ch_print  = (ch >= 8'd32) && (ch <= 8'd126);
  assign lc        = ch_upper ? ch + 8'd32 : ch;
  assign dig       = ch[3:0];

  // Accumulate one decimal digit, clamp at the int limit
  assign prod = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {31'd0, dig};
  assign ovf  = prod > {4'd0, c_sl_pkg::INT_LIMIT};

  // Token that the pending state turns into when it is cut off
  always_comb begin
    fl_vld = 1'b1;
    fl = '0;
    fl.token_start  = tok_begin;
    fl.token_length = 11'd1;
    fl.token_kind   = c_sl_pkg::KIND_ERROR;
    unique case (mode) inside
      M_IDENT: begin
        fl.token_kind   = c_sl_pkg::keyword_kind(window, run_len);
        fl.token_length = run_len;
      end
      M_EQ: fl.token_kind = c_sl_pkg::KIND_ASSIGN;
      M_GT: fl.token_kind = c_sl_pkg::KIND_GT;
      M_LT: fl.token_kind = c_sl_pkg::KIND_LT;
      M_NUMBER: begin
        fl.token_kind      = c_sl_pkg::KIND_NUMBER;
        fl.token_value     = acc;
        fl.token_length    = 11'(digits);
        fl.value_saturated = sat;
      end
      M_BANG, M_QUOTE: fl.token_kind = c_sl_pkg::KIND_ERROR;
      M_CHARGOT: fl.token_length = 11'd2;
      M_STRING: fl.token_length = run_len + 11'd1;
      default: fl_vld = 1'b0;
    endcase
  end

  // Decode a byte that begins a new token
  always_comb begin
    st_vld  = 1'b0;
    st_mode = M_IDLE;
    st = '0;
    st.token_start  = byte_off;
    st.token_length = 11'd1;
    st.token_kind   = c_sl_pkg::KIND_ERROR;
    unique case (ch) inside
      " ", "\t", "\n": st_mode = M_IDLE;
      "=":  st_mode = M_EQ;
      "!":  st_mode = M_BANG;
      ">":  st_mode = M_GT;
      "<":  st_mode = M_LT;
      "'":  st_mode = M_QUOTE;
      "\"": st_mode = M_STRING;
      "(":  begin st_vld = 1'b1; st.token_kind = c_sl_pkg::KIND_LPAREN; end
      ")":  begin st_vld = 1'b1; st.token_kind = c_sl_pkg::KIND_RPAREN; end
      "[":  begin st_vld = 1'b1; st.token_kind = c_sl_pkg::KIND_LBRACK; end
      "]":  begin st_vld = 1'b1; st.token_kind = c_sl_pkg::KIND_RBRACK; end
      "{":  begin st_vld = 1'b1; st.token_kind = c_sl_pkg::KIND_LBRACE; end
      "}":  begin st_vld = 1'b1; st.token_kind = c_sl_pkg::KIND_RBRACE; end
      ",":  begin st_vld = 1'b1; st.token_kind = c_sl_pkg::KIND_COMMA; end
      ";":  begin st_vld = 1'b1; st.token_kind = c_sl_pkg::KIND_SEMI; end
      "+":  begin st_vld = 1'b1; st.token_kind = c_sl_pkg::KIND_PLUS; end
      "-":  begin st_vld = 1'b1; st.token_kind = c_sl_pkg::KIND_MINUS; end
      "*":  begin st_vld = 1'b1; st.token_kind = c_sl_pkg::KIND_STAR; end
      "/":  begin st_vld = 1'b1; st.token_kind = c_sl_pkg::KIND_SLASH; end
      default: begin
        if (ch_letter) begin
          st_mode = M_IDENT;
        end else if (ch_digit) begin
          st_mode = M_NUMBER;
        end else begin
          st_vld = 1'b1;
        end
      end
    endcase
  end

  // Decide whether the pending token takes this byte
  always_comb begin
    absorb  = 1'b0;
    ct_vld  = 1'b0;
    ct_mode = mode;
    ct = '0;
    ct.token_start  = tok_begin;
    ct.token_length = 11'd2;
    ct.token_kind   = c_sl_pkg::KIND_EQ;
    unique case (mode) inside
      M_IDENT:
        absorb = (ch_letter || ch_digit) && (run_len < 11'(c_sl_pkg::MAX_IDENT_LEN));
      M_EQ, M_BANG, M_GT, M_LT: begin
        if (ch == "=") begin
          absorb  = 1'b1;
          ct_vld  = 1'b1;
          ct_mode = M_IDLE;
          if (mode == M_BANG) begin
            ct.token_kind = c_sl_pkg::KIND_NE;
          end else if (mode == M_GT) begin
            ct.token_kind = c_sl_pkg::KIND_GE;
          end else if (mode == M_LT) begin
            ct.token_kind = c_sl_pkg::KIND_LE;
          end
        end
      end
      M_NUMBER:
        absorb = ch_digit && (digits < 4'(c_sl_pkg::MAX_DIGITS));
      M_QUOTE: begin
        absorb  = (ch == "+") || (ch == "-") || (ch == "*") || (ch == "/") ||
                  ch_letter || ch_digit;
        ct_mode = M_CHARGOT;
      end
      M_CHARGOT: begin
        if (ch == "'") begin
          absorb          = 1'b1;
          ct_vld          = 1'b1;
          ct_mode         = M_IDLE;
          ct.token_kind   = c_sl_pkg::KIND_CHARCON;
          ct.token_value  = {23'd0, pend};
          ct.token_length = 11'd3;
        end
      end
      M_STRING: begin
        if (ch == "\"") begin
          absorb          = 1'b1;
          ct_vld          = 1'b1;
          ct_mode         = M_IDLE;
          ct.token_kind   = c_sl_pkg::KIND_STRING;
          ct.token_value  = {20'd0, run_len};
          ct.token_length = run_len + 11'd2;
        end else begin
          absorb = ch_print && (run_len < 11'(c_sl_pkg::MAX_STRING_LEN));
        end
      end
      default: absorb = 1'b0;
    endcase
  end

  // Combine continue, cut-off and restart into next state and results
  always_comb begin
    mode_next      = mode;
    window_next    = window;
    acc_next       = acc;
    digits_next    = digits;
    sat_next       = sat;
    pend_next      = pend;
    run_len_next   = run_len;
    tok_begin_next = tok_begin;
    byte_off_next  = byte_off;
    use_start      = 1'b0;
    first          = fl;
    first_vld      = 1'b0;
    if (src.end_of_input) begin
      first_vld = fl_vld;
      mode_next = M_IDLE;
    end else begin
      byte_off_next = byte_off + 32'd1;
      if (!fl_vld) begin
        use_start = 1'b1;
      end else if (absorb) begin
        mode_next = ct_mode;
        first     = ct;
        first_vld = ct_vld;
        unique case (mode) inside
          M_IDENT: begin
            window_next  = {window[39:0], lc};
            run_len_next = run_len + 11'd1;
          end
          M_NUMBER: begin
            acc_next    = ovf ? c_sl_pkg::INT_LIMIT : prod[30:0];
            sat_next    = sat | ovf;
            digits_next = digits + 4'd1;
          end
          M_QUOTE: pend_next = ch;
          M_STRING: begin
            if (!ct_vld) begin
              run_len_next = run_len + 11'd1;
            end
          end
          default: pend_next = pend;
        endcase
      end else begin
        first_vld = 1'b1;
        use_start = 1'b1;
      end
      if (use_start) begin
        tok_begin_next = byte_off;
        mode_next      = st_mode;
        if (st_mode == M_IDENT) begin
          window_next  = {40'd0, lc};
          run_len_next = 11'd1;
        end
        if (st_mode == M_NUMBER) begin
          acc_next    = {27'd0, dig};
          digits_next = 4'd1;
          sat_next    = 1'b0;
        end
        if (st_mode == M_STRING) begin
          run_len_next = 11'd0;
        end
      end
    end
  end

  // Place the tokens in order and mark the last one
  always_comb begin
    push = '0;
    if (first_vld) begin
      push.first  = first;
      push.second = st;
      push.count  = (use_start && st_vld) ? 2'd2 : 2'd1;
    end else begin
      push.first = st;
      push.count = (use_start && st_vld) ? 2'd1 : 2'd0;
    end
    push.first.last_of_run  = (push.count == 2'd1);
    push.second.last_of_run = 1'b1;
    if (!fire) begin
      push.count = 2'd0;
    end
  end

  // Hold lexer state; advance on each transfer into the core
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      window    <= '0;
      acc       <= '0;
      digits    <= '0;
      sat       <= 1'b0;
      pend      <= '0;
      run_len   <= '0;
      tok_begin <= '0;
      byte_off  <= '0;
    end else if (fire) begin
      mode      <= mode_next;
      window    <= window_next;
      acc       <= acc_next;
      digits    <= digits_next;
      sat       <= sat_next;
      pend      <= pend_next;
      run_len   <= run_len_next;
      tok_begin <= tok_begin_next;
      byte_off  <= byte_off_next;
    end
  end

  `C_SL_ASSERT_NEXT(a_end_clears_mode, clk, rst, fire && src.end_of_input, mode == M_IDLE)
  `C_SL_ASSERT_NEXT(a_offset_counts, clk, rst, fire && !src.end_of_input, byte_off == $past(byte_off) + 32'd1)
  `C_SL_ASSERT_NEXT(a_idle_holds, clk, rst, !fire, $stable(byte_off) && $stable(mode))
  `C_SL_ASSERT_SAME(a_end_single, clk, rst, push.count == 2'd2, !src.end_of_input)

endmodule

>>> design/c_sl_fifo.sv
// Result queue: takes up to two tokens per cycle, delivers one per transfer.
// Depends on c_sl_pkg and c_subset_lexer_top_assert.svh.
`timescale 1ns / 1ps
`include "c_subset_lexer_top_assert.svh"

module c_sl_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  c_sl_pkg::tok_pair_t  push,
  output logic                 room,
  output logic                 tok_valid,
  input  logic                 tok_ready,
  output c_sl_pkg::tok_t       tok
);

  c_sl_pkg::tok_t                mem [c_sl_pkg::FIFO_DEPTH];
  logic [c_sl_pkg::PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [c_sl_pkg::CNT_W-1:0]    count, count_next;
  logic                          pop;

  // Drain from the head, accept while two slots are free
  assign tok_valid  = (count != '0);
  assign tok        = mem[rd_ptr];
  assign pop        = tok_valid && tok_ready;
  assign room       = (count <= c_sl_pkg::CNT_W'(c_sl_pkg::FIFO_DEPTH - 2));
  assign count_next = count + c_sl_pkg::CNT_W'(push.count) - c_sl_pkg::CNT_W'(pop);

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + c_sl_pkg::PTR_W'(push.count);
      rd_ptr <= rd_ptr + c_sl_pkg::PTR_W'(pop);
      count  <= count_next;
    end
  end

  // Store tokens in arrival order
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + c_sl_pkg::PTR_W'(1)] <= push.second;
    end
  end

  `C_SL_ASSERT_SAME(a_push_has_room, clk, rst, push.count != 2'd0, room)
  `C_SL_ASSERT_NEXT(a_pop_only, clk, rst, pop && push.count == 2'd0, count == $past(count) - c_sl_pkg::CNT_W'(1))

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the C subset lexer top level (c_subset_lexer_top).
// Depends on c_sl_pkg for the source and token structs and the token codes.
// Runs directed and random source text, predicts every token and checks them in order.
`timescale 1ns / 1ps

module testbench;

  typedef enum logic [3:0] {
    LX_IDLE, LX_IDENT, LX_EQ, LX_BANG, LX_GT, LX_LT,
    LX_NUMBER, LX_QUOTE, LX_CHARGOT, LX_STRING
  } lex_mode_t;

  // Predict tokens from accepted source items and match them against the output
  class token_scoreboard;
    c_sl_pkg::tok_t expected_tokens[$];
    c_sl_pkg::tok_t step_tokens[$];
    int unsigned    tokens_checked;
    int unsigned    mismatches;
    string          kw_text [12];
    logic [5:0]     kw_code [12];
    lex_mode_t      mode;
    logic [47:0]    word_tail;
    logic [30:0]    number_value;
    logic [3:0]     digit_cnt;
    logic           clamped;
    logic [7:0]     char_code;
    logic [10:0]    body_len;
    logic [31:0]    begin_offset;
    logic [31:0]    offset;

    function new();
      kw_text = '{"const", "int", "char", "void", "if", "else",
                  "while", "for", "scanf", "printf", "return", "main"};
      kw_code = '{c_sl_pkg::KIND_CONST, c_sl_pkg::KIND_INT, c_sl_pkg::KIND_CHAR,
                  c_sl_pkg::KIND_VOID, c_sl_pkg::KIND_IF, c_sl_pkg::KIND_ELSE,
                  c_sl_pkg::KIND_WHILE, c_sl_pkg::KIND_FOR, c_sl_pkg::KIND_SCANF,
                  c_sl_pkg::KIND_PRINTF, c_sl_pkg::KIND_RETURN, c_sl_pkg::KIND_MAIN};
      mode = LX_IDLE;
      word_tail = '0;
      number_value = '0;
      digit_cnt = '0;
      clamped = 1'b0;
      char_code = '0;
      body_len = '0;
      begin_offset = '0;
      offset = '0;
      tokens_checked = 0;
      mismatches = 0;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function logic [7:0] to_lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function void push(logic [5:0] kind, logic [30:0] value, logic [31:0] start,
                       logic [10:0] len, logic sat);
      c_sl_pkg::tok_t t;
      t.token_kind      = kind;
      t.token_value     = value;
      t.token_start     = start;
      t.token_length    = len;
      t.value_saturated = sat;
      t.last_of_run     = 1'b0;
      step_tokens.push_back(t);
    endfunction

    // Short words may be keywords; compare the lower-cased tail with the table
    function logic [5:0] word_kind();
      logic [47:0] kw_bytes;
      logic [5:0]  kind;
      kind = c_sl_pkg::KIND_IDENT;
      if (body_len <= 6) begin
        for (int k = 0; k < 12; k++) begin
          kw_bytes = '0;
          for (int j = 0; j < kw_text[k].len(); j++) begin
            kw_bytes = {kw_bytes[39:0], 8'(kw_text[k][j])};
          end
          if (body_len == kw_text[k].len() && kw_bytes == word_tail) begin
            kind = kw_code[k];
          end
        end
      end
      return kind;
    endfunction

    // Close whatever token is pending
    function void flush_pending();
      case (mode)
        LX_IDENT:          push(word_kind(), '0, begin_offset, body_len, 1'b0);
        LX_EQ:             push(c_sl_pkg::KIND_ASSIGN, '0, begin_offset, 11'd1, 1'b0);
        LX_GT:             push(c_sl_pkg::KIND_GT, '0, begin_offset, 11'd1, 1'b0);
        LX_LT:             push(c_sl_pkg::KIND_LT, '0, begin_offset, 11'd1, 1'b0);
        LX_NUMBER:         push(c_sl_pkg::KIND_NUMBER, number_value, begin_offset,
                                11'(digit_cnt), clamped);
        LX_BANG, LX_QUOTE: push(c_sl_pkg::KIND_ERROR, '0, begin_offset, 11'd1, 1'b0);
        LX_CHARGOT:        push(c_sl_pkg::KIND_ERROR, '0, begin_offset, 11'd2, 1'b0);
        LX_STRING:         push(c_sl_pkg::KIND_ERROR, '0, begin_offset, body_len + 11'd1,
                                1'b0);
        default: ;
      endcase
      mode = LX_IDLE;
    endfunction

    // Begin a new token at the current byte
    function void start_token(logic [7:0] c);
      begin_offset = offset;
      case (c)
        " ", "\t", "\n": ;
        "=":  mode = LX_EQ;
        "!":  mode = LX_BANG;
        ">":  mode = LX_GT;
        "<":  mode = LX_LT;
        "(":  push(c_sl_pkg::KIND_LPAREN, '0, offset, 11'd1, 1'b0);
        ")":  push(c_sl_pkg::KIND_RPAREN, '0, offset, 11'd1, 1'b0);
        "[":  push(c_sl_pkg::KIND_LBRACK, '0, offset, 11'd1, 1'b0);
        "]":  push(c_sl_pkg::KIND_RBRACK, '0, offset, 11'd1, 1'b0);
        "{":  push(c_sl_pkg::KIND_LBRACE, '0, offset, 11'd1, 1'b0);
        "}":  push(c_sl_pkg::KIND_RBRACE, '0, offset, 11'd1, 1'b0);
        ",":  push(c_sl_pkg::KIND_COMMA, '0, offset, 11'd1, 1'b0);
        ";":  push(c_sl_pkg::KIND_SEMI, '0, offset, 11'd1, 1'b0);
        "+":  push(c_sl_pkg::KIND_PLUS, '0, offset, 11'd1, 1'b0);
        "-":  push(c_sl_pkg::KIND_MINUS, '0, offset, 11'd1, 1'b0);
        "*":  push(c_sl_pkg::KIND_STAR, '0, offset, 11'd1, 1'b0);
        "/":  push(c_sl_pkg::KIND_SLASH, '0, offset, 11'd1, 1'b0);
        "'":  mode = LX_QUOTE;
        "\"": begin
          mode = LX_STRING;
          body_len = '0;
        end
        default: begin
          if (is_letter(c)) begin
            mode = LX_IDENT;
            word_tail = {40'd0, to_lower(c)};
            body_len = 11'd1;
          end else if (is_digit(c)) begin
            mode = LX_NUMBER;
            number_value = 31'(c - "0");
            digit_cnt = 4'd1;
            clamped = 1'b0;
          end else begin
            push(c_sl_pkg::KIND_ERROR, '0, offset, 11'd1, 1'b0);
          end
        end
      endcase
    endfunction

    // Try to extend the pending token; return 1 when the byte is absorbed
    function bit continue_token(logic [7:0] c);
      bit          taken;
      logic [63:0] grown;
      taken = 1'b0;
      case (mode)
        LX_IDENT: begin
          if ((is_letter(c) || is_digit(c)) && body_len < c_sl_pkg::MAX_IDENT_LEN) begin
            word_tail = {word_tail[39:0], to_lower(c)};
            body_len++;
            taken = 1'b1;
          end
        end
        LX_EQ, LX_BANG, LX_GT, LX_LT: begin
          if (c == "=") begin
            push(mode == LX_EQ ? c_sl_pkg::KIND_EQ : mode == LX_BANG ? c_sl_pkg::KIND_NE :
                 mode == LX_GT ? c_sl_pkg::KIND_GE : c_sl_pkg::KIND_LE,
                 '0, begin_offset, 11'd2, 1'b0);
            mode = LX_IDLE;
            taken = 1'b1;
          end
        end
        LX_NUMBER: begin
          if (is_digit(c) && digit_cnt < c_sl_pkg::MAX_DIGITS) begin
            grown = 64'(number_value) * 64'd10 + 64'(c - "0");
            if (grown > 64'(c_sl_pkg::INT_LIMIT)) begin
              grown = 64'(c_sl_pkg::INT_LIMIT);
              clamped = 1'b1;
            end
            number_value = grown[30:0];
            digit_cnt++;
            taken = 1'b1;
          end
        end
        LX_QUOTE: begin
          if (c == "+" || c == "-" || c == "*" || c == "/" || is_letter(c) || is_digit(c))
          begin
            char_code = c;
            mode = LX_CHARGOT;
            taken = 1'b1;
          end
        end
        LX_CHARGOT: begin
          if (c == "'") begin
            push(c_sl_pkg::KIND_CHARCON, 31'(char_code), begin_offset, 11'd3, 1'b0);
            mode = LX_IDLE;
            taken = 1'b1;
          end
        end
        LX_STRING: begin
          if (c == "\"") begin
            push(c_sl_pkg::KIND_STRING, 31'(body_len), begin_offset, body_len + 11'd2,
                 1'b0);
            mode = LX_IDLE;
            taken = 1'b1;
          end else if (c >= 8'd32 && c <= 8'd126 && body_len < c_sl_pkg::MAX_STRING_LEN)
          begin
            body_len++;
            taken = 1'b1;
          end
        end
        default: ;
      endcase
      return taken;
    endfunction

    // Note one accepted source transfer and queue the tokens it causes
    function void note_source(c_sl_pkg::src_t it);
      c_sl_pkg::tok_t tail;
      step_tokens.delete();
      if (it.end_of_input) begin
        flush_pending();
      end else begin
        if (mode == LX_IDLE) begin
          start_token(it.char_byte);
        end else if (!continue_token(it.char_byte)) begin
          flush_pending();
          start_token(it.char_byte);
        end
        offset++;
      end
      if (step_tokens.size() > 0) begin
        tail = step_tokens.pop_back();
        tail.last_of_run = 1'b1;
        step_tokens.push_back(tail);
      end
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    // Compare one token transfer with the oldest prediction
    function void check_token(c_sl_pkg::tok_t got);
      c_sl_pkg::tok_t want;
      bit             bad;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: token with nothing expected: kind %0d value %0d start %0d len %0d",
                   $realtime, got.token_kind, got.token_value, got.token_start,
                   got.token_length);
        end
        return;
      end
      want = expected_tokens.pop_front();
      tokens_checked++;
      bad = (got.token_kind !== want.token_kind) ||
            (got.token_value !== want.token_value) ||
            (got.token_start !== want.token_start) ||
            (got.token_length !== want.token_length) ||
            (got.value_saturated !== want.value_saturated) ||
            (got.last_of_run !== want.last_of_run);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: token mismatch, expected kind %0d value %0d start %0d len %0d",
                   $realtime, want.token_kind, want.token_value, want.token_start,
                   want.token_length);
          $display("          expected sat %0b last %0b",
                   want.value_saturated, want.last_of_run);
          $display("          got      kind %0d value %0d start %0d len %0d sat %0b last %0b",
                   got.token_kind, got.token_value, got.token_start,
                   got.token_length, got.value_saturated, got.last_of_run);
        end
      end
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           src_valid;
  logic           src_ready;
  c_sl_pkg::src_t src;
  logic           tok_valid;
  logic           tok_ready;
  c_sl_pkg::tok_t tok;

  token_scoreboard sb;
  int unsigned     items_sent;
  int              burst_left;
  bit              holdoff_done;
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string op_texts [20] = '{"==", "!=", ">=", "<=", ">", "<", "=", "!", "(", ")",
                           "[", "]", "{", "}", ",", ";", "+", "-", "*", "/"};

  c_subset_lexer_top uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src       (src),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Check every token transfer
  always @(posedge clk) begin
    if (!rst && tok_valid && tok_ready) begin
      sb.check_token(tok);
    end
  end

  // Offer one item, hold it until the transfer, then idle at burst ends
  task automatic send_item(input c_sl_pkg::src_t it);
    src_valid <= 1'b1;
    src <= it;
    do @(posedge clk); while (!src_ready);
    sb.note_source(it);
    items_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 30);
    end
  endtask

  task automatic send_byte(input logic [7:0] c);
    c_sl_pkg::src_t it;
    it.char_byte = c;
    it.end_of_input = 1'b0;
    send_item(it);
  endtask

  task automatic send_end();
    c_sl_pkg::src_t it;
    it.char_byte = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    send_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]));
  endtask

  // Printable string body byte, never the closing quote
  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    c = 8'($urandom_range(32, 125));
    if (c >= 8'd34) c++;
    return c;
  endfunction

  // Stop offering until every predicted token has come out
  task automatic wait_all_tokens();
    src_valid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Open a string, fill its body, then send the given closing byte
  task automatic send_long_string(input int body, input logic [7:0] closer);
    send_byte("\"");
    repeat (body) send_byte(body_byte());
    send_byte(closer);
  endtask

  // One random token, mostly well formed, followed by an optional separator
  task automatic send_random_token();
    int    pick;
    int    len;
    string kw;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      if ($urandom_range(0, 2) == 0) begin
        // keyword in mixed case, sometimes with an extra tail
        kw = sb.kw_text[$urandom_range(0, 11)];
        for (int i = 0; i < kw.len(); i++) begin
          send_byte(($urandom_range(0, 1) == 1) ? 8'(kw[i]) - 8'd32 : 8'(kw[i]));
        end
        if ($urandom_range(0, 3) == 0) send_byte(8'(word_chars[$urandom_range(0, 62)]));
      end else begin
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(45, 60) : $urandom_range(1, 9);
        send_byte(8'(word_chars[$urandom_range(0, 52)]));
        repeat (len - 1) send_byte(8'(word_chars[$urandom_range(0, 62)]));
      end
    end else if (pick < 40) begin
      case ($urandom_range(0, 5))
        0: send_text("2147483647");
        1: send_text("2147483648");
        2: begin
          len = $urandom_range(10, 13);
          send_byte(8'($urandom_range(50, 57)));
          repeat (len - 1) send_byte(8'($urandom_range(48, 57)));
        end
        default: begin
          len = $urandom_range(1, 5);
          repeat (len) send_byte(8'($urandom_range(48, 57)));
        end
      endcase
    end else if (pick < 65) begin
      send_text(op_texts[$urandom_range(0, 19)]);
    end else if (pick < 73) begin
      send_byte("'");
      case ($urandom_range(0, 5))
        0: send_byte(8'($urandom_range(0, 255)));
        1: send_byte(8'(word_chars[$urandom_range(0, 62)]));
        default: begin
          if ($urandom_range(0, 4) == 0) send_byte(8'(op_texts[$urandom_range(16, 19)][0]));
          else send_byte(8'(word_chars[$urandom_range(0, 62)]));
          send_byte("'");
        end
      endcase
    end else if (pick < 83) begin
      send_byte("\"");
      repeat ($urandom_range(0, 12)) send_byte(body_byte());
      if ($urandom_range(0, 7) == 0) begin
        send_byte(($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 31)) :
                                                8'($urandom_range(127, 255)));
      end else begin
        send_byte("\"");
      end
    end else if (pick < 90) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_end();
    end
    case ($urandom_range(0, 9))
      4, 5:    send_byte(" ");
      6:       send_byte("\t");
      7:       send_byte("\n");
      8:       send_end();
      default: ;
    endcase
  endtask

  // Receiver: shifting ready patterns plus one long hold-off
  initial begin
    int          pattern;
    int unsigned cycle;
    tok_ready = 1'b0;
    holdoff_done = 1'b0;
    cycle = 0;
    pattern = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      cycle++;
      if (cycle % 64 == 0) pattern = $urandom_range(0, 3);
      if (!holdoff_done && sb.tokens_checked >= 60) begin
        tok_ready <= 1'b0;
        repeat (400) @(negedge clk);
        holdoff_done = 1'b1;
      end
      case (pattern)
        0:       tok_ready <= 1'b1;
        1:       tok_ready <= ($urandom_range(0, 1) == 1);
        2:       tok_ready <= ($urandom_range(0, 3) == 0);
        default: tok_ready <= (cycle % 8) < 5;
      endcase
    end
  end

  // Stimulus and final verdict
  initial begin
    int unsigned next_pause;
    rst = 1'b1;
    src_valid = 1'b0;
    src = '0;
    items_sent = 0;
    burst_left = 20;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: operators, punctuation, the byte extremes, a pending '=' flushed at end
    send_text("A!=1>=b<=(){}[],;+-*/");
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte("=");
    send_end();
    wait_all_tokens();

    // Random token stream with periodic full drains
    next_pause = items_sent + 200;
    while (items_sent < 420) begin
      send_random_token();
      if (items_sent >= next_pause) begin
        wait_all_tokens();
        next_pause += 200;
      end
    end

    // Longest legal string body, then one more byte that overflows and restarts
    send_long_string(c_sl_pkg::MAX_STRING_LEN, "x");
    send_byte(";");
    send_end();

    wait_all_tokens();
    repeat (32) @(posedge clk);
    $display("lexed %0d source items into %0d checked tokens, %0d mismatches",
             items_sent, sb.tokens_checked, sb.mismatches);
    $display("covered keywords, identifiers, numbers, operators, char constants, strings, errors");
    if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/c_sl_pkg.sv
design/c_sl_core.sv
design/c_sl_fifo.sv
design/c_subset_lexer_top.sv
sim/testbench.sv
